@@ hw/rtl/ped_pkg.sv @@
// ----------------------------------------------------------------------------
// ped_pkg
// Shared types and constants of the percent and entity decoder.
// ----------------------------------------------------------------------------
package ped_pkg;

    localparam int HOLD_MAX  = 5;
    localparam int CNT_W     = 3;
    localparam int JOB_DEPTH = 4;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       text_done;
    } out_item_t;

    // One request's worth of output: a held prefix, then an optional tail byte.
    typedef struct packed {
        logic [HOLD_MAX-1:0][7:0] held;
        logic [CNT_W-1:0]         pcnt;
        logic                     has_tail;
        logic [7:0]               tail;
        logic                     end_of_text;
    } job_t;

endpackage

@@ hw/rtl/ped_front.sv @@
// ----------------------------------------------------------------------------
// ped_front
// Classifies each incoming byte against the held prefix and issues a job.
// ----------------------------------------------------------------------------
module ped_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  ped_pkg::in_item_t item,
    output logic              job_push,
    output ped_pkg::job_t     job
);

    localparam int ENT_NUM = 5;
    localparam int ENT_W   = 6;

    localparam logic [7:0] ENT_TEXT [ENT_NUM][ENT_W] = '{
        '{"&", "a", "m", "p", ";", 8'h00},
        '{"&", "l", "t", ";", 8'h00, 8'h00},
        '{"&", "g", "t", ";", 8'h00, 8'h00},
        '{"&", "q", "u", "o", "t", ";"},
        '{"&", "#", "3", "9", ";", 8'h00}
    };
    localparam logic [2:0] ENT_LEN  [ENT_NUM] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd5};
    localparam logic [7:0] ENT_CHAR [ENT_NUM] = '{"&", "<", ">", "\"", "'"};

    typedef enum logic [2:0] {
        K_IDLE = 3'b001,
        K_PCT  = 3'b010,
        K_ENT  = 3'b100
    } kind_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
               (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        if (c >= "0" && c <= "9")
            d = c - "0";
        else if (c >= "a" && c <= "f")
            d = c - "a" + 8'd10;
        else
            d = c - "A" + 8'd10;
        return d[3:0];
    endfunction

    logic [ped_pkg::HOLD_MAX-1:0][7:0] held_reg, held_next;
    logic [ped_pkg::CNT_W-1:0]         hc_reg, hc_next;
    kind_t                             kind_reg, kind_next;

    logic       ent_hit, ent_done;
    logic [7:0] ent_val;
    logic       ok, bad;

    logic       ext_hold, ext_done, ext_fail;
    logic [7:0] done_val;
    logic       special;
    logic [7:0] b;
    logic       eot;

    assign b       = item.in_byte;
    assign eot     = item.end_of_text;
    assign special = (b == "%") || (b == "&");

    always_comb
    begin
        ent_hit  = 1'b0;
        ent_done = 1'b0;
        ent_val  = 8'h00;
        for (int k = 0; k < ENT_NUM; k++)
        begin
            bad = 1'b0;
            for (int i = 0; i < ped_pkg::HOLD_MAX; i++)
            begin
                if (3'(i) < hc_reg && held_reg[i] != ENT_TEXT[k][i])
                    bad = 1'b1;
            end
            ok = (({1'b0, hc_reg} + 4'd1) <= {1'b0, ENT_LEN[k]}) && !bad &&
                 (ENT_TEXT[k][hc_reg] == b);
            if (!ent_hit && ok)
            begin
                ent_hit  = 1'b1;
                ent_done = (({1'b0, hc_reg} + 4'd1) == {1'b0, ENT_LEN[k]});
                ent_val  = ENT_CHAR[k];
            end
        end
    end

    always_comb
    begin
        ext_hold = 1'b0;
        ext_done = 1'b0;
        ext_fail = 1'b0;
        done_val = ent_val;
        unique case (kind_reg)
            K_IDLE:
            begin
            end
            K_PCT:
            begin
                if (!is_hex(b))
                    ext_fail = 1'b1;
                else if (hc_reg == 3'd1)
                    ext_hold = 1'b1;
                else if (hc_reg == 3'd2)
                begin
                    ext_done = 1'b1;
                    done_val = {hex_val(held_reg[1]), hex_val(b)};
                end
                else
                    ext_fail = 1'b1;
            end
            K_ENT:
            begin
                if (ent_hit)
                begin
                    ext_done = ent_done;
                    ext_hold = !ent_done;
                end
                else
                    ext_fail = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        held_next        = held_reg;
        hc_next          = hc_reg;
        kind_next        = kind_reg;
        job.held         = held_reg;
        job.pcnt         = '0;
        job.has_tail     = 1'b0;
        job.tail         = b;
        job.end_of_text  = eot;
        if (ext_done)
        begin
            job.tail     = done_val;
            job.has_tail = 1'b1;
            hc_next      = '0;
            kind_next    = K_IDLE;
        end
        else if (ext_hold)
        begin
            if (hc_reg < 3'(ped_pkg::HOLD_MAX))
                held_next[hc_reg] = b;
            hc_next = hc_reg + 3'd1;
            if (eot)
            begin
                job.pcnt     = hc_reg;
                job.has_tail = 1'b1;
                hc_next      = '0;
                kind_next    = K_IDLE;
            end
        end
        else
        begin
            job.pcnt = ext_fail ? hc_reg : '0;
            if (special && !eot)
            begin
                held_next[0] = b;
                hc_next      = 3'd1;
                kind_next    = (b == "%") ? K_PCT : K_ENT;
            end
            else
            begin
                job.has_tail = 1'b1;
                hc_next      = '0;
                kind_next    = K_IDLE;
            end
        end
    end

    assign job_push = accept && (job.has_tail || job.pcnt != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg   <= '0;
            kind_reg <= K_IDLE;
        end
        else if (accept)
        begin
            hc_reg   <= hc_next;
            kind_reg <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            held_reg <= held_next;
    end

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (kind_reg == K_IDLE) == (hc_reg == '0))
        else $error("match kind and held count disagree");

    a_pct_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (kind_reg == K_PCT) |-> (hc_reg == 3'd1 || hc_reg == 3'd2))
        else $error("percent escape holds a wrong byte count");

endmodule

@@ hw/rtl/ped_job_fifo.sv @@
// ----------------------------------------------------------------------------
// ped_job_fifo
// Short queue of jobs between the classifier and the serializer.
// ----------------------------------------------------------------------------
module ped_job_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ped_pkg::job_t wr_job,
    output logic          full,
    input  logic          pop,
    output ped_pkg::job_t rd_job,
    output logic          empty
);

    ped_pkg::job_t                   mem_reg [ped_pkg::JOB_DEPTH];
    logic [ped_pkg::JOB_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ped_pkg::JOB_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ped_pkg::JOB_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                            do_push, do_pop;

    assign full    = (cnt_reg == ped_pkg::JOB_CNT_W'(ped_pkg::JOB_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_job  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == ped_pkg::JOB_PTR_W'(ped_pkg::JOB_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == ped_pkg::JOB_PTR_W'(ped_pkg::JOB_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= ped_pkg::JOB_CNT_W'(ped_pkg::JOB_DEPTH))
        else $error("job queue count overflow");

endmodule

@@ hw/rtl/ped_back.sv @@
// ----------------------------------------------------------------------------
// ped_back
// Serializes each job into decoded bytes, one per cycle while there is room, into a result queue.
// ----------------------------------------------------------------------------
module ped_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_empty,
    input  ped_pkg::job_t      job,
    output logic               job_pop,
    output logic               empty,
    input  logic               pop,
    output ped_pkg::out_item_t result
);

    logic [ped_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [ped_pkg::CNT_W-1:0] total;
    logic                      last, step;
    ped_pkg::out_item_t        res_item;

    ped_pkg::out_item_t        oq_reg [2];
    logic                      oq_wr_reg, oq_rd_reg;
    logic [1:0]                oq_cnt_reg, oq_cnt_next;
    logic                      oq_full, do_pop;

    assign total   = job.pcnt + {{(ped_pkg::CNT_W-1){1'b0}}, job.has_tail};
    assign last    = (idx_reg == total - 1'b1);
    assign oq_full = (oq_cnt_reg == 2'd2);
    assign step    = !job_empty && !oq_full;
    assign job_pop = step && last;
    assign empty   = (oq_cnt_reg == 2'd0);
    assign do_pop  = pop && !empty;
    assign result  = oq_reg[oq_rd_reg];

    always_comb
    begin
        res_item.out_byte    = (idx_reg < job.pcnt) ? job.held[idx_reg] : job.tail;
        res_item.last_of_run = last;
        res_item.text_done   = last && job.end_of_text;
        idx_next = idx_reg;
        if (step)
            idx_next = last ? '0 : idx_reg + 1'b1;
        oq_cnt_next = oq_cnt_reg;
        if (step && !do_pop)
            oq_cnt_next = oq_cnt_reg + 2'd1;
        else if (do_pop && !step)
            oq_cnt_next = oq_cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            oq_wr_reg  <= 1'b0;
            oq_rd_reg  <= 1'b0;
            oq_cnt_reg <= 2'd0;
        end
        else
        begin
            idx_reg    <= idx_next;
            oq_cnt_reg <= oq_cnt_next;
            if (step)
                oq_wr_reg <= !oq_wr_reg;
            if (do_pop)
                oq_rd_reg <= !oq_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            oq_reg[oq_wr_reg] <= res_item;
    end

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        !job_empty |-> (idx_reg < total))
        else $error("serializer index past end of job");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_empty |-> (idx_reg == '0))
        else $error("serializer index left over without a job");

endmodule

@@ hw/rtl/percent_and_entity_decoder.sv @@
// ----------------------------------------------------------------------------
// percent_and_entity_decoder
// Streaming decoder for %XY escapes and the five basic HTML entities.
// ----------------------------------------------------------------------------
// Input queue: drive item and raise push; the request is taken on a clock
// edge with push high and full low. end_of_text marks the string's last byte.
// Result queue: while empty is low the oldest result sits on result; it is
// taken on a clock edge with pop high. Each request yields zero to six
// results; last_of_run flags the last one of a request, text_done the last
// one of the string.
// Throughput: one request per cycle while requests give at most one result and
// the job queue has room; the serializer emits one result per cycle while the
// result queue has room, and ends one request's results before the next. A
// four-deep job queue decouples the classifier from the serializer.
// When the receiver stalls, the two-entry result queue fills, then the job
// queue, and full rises. Reset empties both queues and drops any held prefix.
// ----------------------------------------------------------------------------
module percent_and_entity_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  ped_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output ped_pkg::out_item_t result
);

    logic          accept;
    logic          job_push, job_pop, job_full, job_empty;
    ped_pkg::job_t wr_job, rd_job;

    assign full   = job_full;
    assign accept = push && !job_full;

    ped_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .job_push (job_push),
        .job      (wr_job)
    );

    ped_job_fifo u_job_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (job_push),
        .wr_job (wr_job),
        .full   (job_full),
        .pop    (job_pop),
        .rd_job (rd_job),
        .empty  (job_empty)
    );

    ped_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job       (rd_job),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

@@ tb/sv/tb_percent_and_entity_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_percent_and_entity_decoder
// Self-checking bench for the streaming percent/entity decoder. Strings are
// fed one byte per request under random push/pop idling. A scoreboard class
// decodes every accepted request and compares each popped result in order.
// ----------------------------------------------------------------------------
module tb_percent_and_entity_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] text_q_t[$];
    typedef enum logic [1:0] {MATCH_IDLE, MATCH_PCT, MATCH_ENT} match_t;
    typedef enum logic [1:0] {FIT_NONE, FIT_HELD, FIT_DONE} fit_t;

    localparam logic [7:0] CH_PCT  = "%";
    localparam logic [7:0] CH_AMP  = "&";
    localparam logic [7:0] CH_ZERO = "0";
    localparam logic [7:0] CH_NINE = "9";
    localparam logic [7:0] CH_LO_A = "a";
    localparam logic [7:0] CH_LO_F = "f";
    localparam logic [7:0] CH_UP_A = "A";
    localparam logic [7:0] CH_UP_F = "F";
    localparam int NUM_ENT      = 5;
    localparam int MAX_REPORTS  = 10;
    localparam int TOTAL_ITEMS  = 220;
    localparam int DRAIN        = 20;
    localparam int LIMIT        = 200000;

    class decode_scoreboard;
        logic [7:0] held [ped_pkg::HOLD_MAX];
        int unsigned held_n;
        match_t      kind;
        logic [7:0]  run_q[$];
        ped_pkg::out_item_t pending_bytes[$];
        int          errors;

        function new();
            held_n = 0;
            kind   = MATCH_IDLE;
            errors = 0;
        endfunction

        static function string entity_text(int k);
            case (k)
                0:       return "&amp;";
                1:       return "&lt;";
                2:       return "&gt;";
                3:       return "&quot;";
                default: return "&#39;";
            endcase
        endfunction

        static function logic [7:0] entity_char(int k);
            case (k)
                0:       return "&";
                1:       return "<";
                2:       return ">";
                3:       return "\"";
                default: return "'";
            endcase
        endfunction

        static function int hex_value(logic [7:0] c);
            if (c >= CH_ZERO && c <= CH_NINE)
                return int'(c - CH_ZERO);
            if (c >= CH_LO_A && c <= CH_LO_F)
                return int'(c - CH_LO_A) + 10;
            if (c >= CH_UP_A && c <= CH_UP_F)
                return int'(c - CH_UP_A) + 10;
            return 16;
        endfunction

        function void keep(logic [7:0] b);
            if (held_n < ped_pkg::HOLD_MAX)
            begin
                held[held_n] = b;
                held_n++;
            end
        endfunction

        function void flush();
            for (int i = 0; i < held_n; i++)
                run_q = {run_q, held[i]};
            held_n = 0;
            kind   = MATCH_IDLE;
        endfunction

        function void open_match(logic [7:0] b);
            if (b == CH_PCT)
            begin
                kind = MATCH_PCT;
                keep(b);
            end
            else if (b == CH_AMP)
            begin
                kind = MATCH_ENT;
                keep(b);
            end
            else
                run_q = {run_q, b};
        endfunction

        // FIT_DONE leaves the decoded byte in v
        function fit_t extend(logic [7:0] b, output logic [7:0] v);
            string s;
            bit    same;
            v = '0;
            if (kind == MATCH_PCT)
            begin
                if (hex_value(b) > 15)
                    return FIT_NONE;
                if (held_n == 1)
                begin
                    keep(b);
                    return FIT_HELD;
                end
                if (held_n == 2)
                begin
                    v = 8'(hex_value(held[1]) * 16 + hex_value(b));
                    return FIT_DONE;
                end
                return FIT_NONE;
            end
            if (kind == MATCH_ENT && held_n >= 1)
            begin
                for (int k = 0; k < NUM_ENT; k++)
                begin
                    s = entity_text(k);
                    if (held_n + 1 > s.len())
                        continue;
                    same = 1'b1;
                    for (int i = 0; i < held_n; i++)
                        if (held[i] != s[i])
                            same = 1'b0;
                    if (!same || s[held_n] != b)
                        continue;
                    if (held_n + 1 == s.len())
                    begin
                        v = entity_char(k);
                        return FIT_DONE;
                    end
                    keep(b);
                    return FIT_HELD;
                end
            end
            return FIT_NONE;
        endfunction

        function void note_request(ped_pkg::in_item_t it);
            logic [7:0]         v;
            fit_t               r;
            ped_pkg::out_item_t e;
            run_q.delete();
            if (held_n == 0 || kind == MATCH_IDLE)
            begin
                held_n = 0;
                kind   = MATCH_IDLE;
                open_match(it.in_byte);
            end
            else
            begin
                r = extend(it.in_byte, v);
                if (r == FIT_DONE)
                begin
                    held_n = 0;
                    kind   = MATCH_IDLE;
                    run_q  = {run_q, v};
                end
                else if (r == FIT_NONE)
                begin
                    flush();
                    open_match(it.in_byte);
                end
            end
            if (it.end_of_text)
                flush();
            foreach (run_q[i])
            begin
                e.out_byte    = run_q[i];
                e.last_of_run = (i == run_q.size() - 1);
                e.text_done   = e.last_of_run && it.end_of_text;
                pending_bytes = {pending_bytes, e};
            end
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        function void check_result(ped_pkg::out_item_t got);
            ped_pkg::out_item_t e;
            if (pending_bytes.size() == 0)
            begin
                report($sformatf("unexpected result: byte %02h last %0b done %0b",
                                 got.out_byte, got.last_of_run, got.text_done));
                return;
            end
            e = pending_bytes.pop_front();
            if (got.out_byte !== e.out_byte || got.last_of_run !== e.last_of_run ||
                got.text_done !== e.text_done)
                report($sformatf({"mismatch: expected byte %02h last %0b done %0b,",
                                  " got byte %02h last %0b done %0b"},
                                 e.out_byte, e.last_of_run, e.text_done,
                                 got.out_byte, got.last_of_run, got.text_done));
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    ped_pkg::in_item_t  item;
    logic               empty;
    logic               pop;
    ped_pkg::out_item_t result;

    int send_idle = 16;
    int recv_idle = 54;
    int n_sent    = 0;
    int cycles    = 0;

    decode_scoreboard sb = new();

    percent_and_entity_decoder uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result(result);
    end

    function automatic text_q_t str2q(string s);
        text_q_t q;
        for (int i = 0; i < s.len(); i++)
            q = {q, s[i]};
        return q;
    endfunction

    function automatic logic [7:0] hex_char();
        int d;
        d = $urandom_range(15);
        if (d < 10)
            return CH_ZERO + 8'(d);
        return ($urandom_range(1) ? CH_UP_A : CH_LO_A) + 8'(d - 10);
    endfunction

    // half whole escapes/entities, a fifth cut short, the rest plain bytes
    function automatic text_q_t make_text();
        text_q_t q;
        text_q_t tok;
        int      sel;
        int      cut;
        repeat ($urandom_range(1, 6))
        begin
            sel = $urandom_range(99);
            tok.delete();
            if (sel < 70)
            begin
                if ($urandom_range(1))
                begin
                    tok = {tok, CH_PCT};
                    tok = {tok, hex_char()};
                    tok = {tok, hex_char()};
                end
                else
                    tok = str2q(decode_scoreboard::entity_text($urandom_range(NUM_ENT - 1)));
                if (sel >= 50)
                begin
                    cut = $urandom_range(1, tok.size() - 1);
                    while (tok.size() > cut)
                        void'(tok.pop_back());
                    if ($urandom_range(1))
                        tok = {tok, 8'($urandom_range(255))};
                end
            end
            else
                tok = {tok, 8'($urandom_range(255))};
            q = {q, tok};
        end
        return q;
    endfunction

    task automatic send_text(text_q_t s);
        ped_pkg::in_item_t it;
        foreach (s[i])
        begin
            it.in_byte     = s[i];
            it.end_of_text = (i == s.size() - 1);
            while ($urandom_range(99) < send_idle)
            begin
                push <= 1'b0;
                @(posedge clk);
            end
            push <= 1'b1;
            item <= it;
            do
                @(posedge clk);
            while (full);
            sb.note_request(it);
            n_sent++;
        end
    endtask

    initial
    begin
        text_q_t q;
        int      target;
        rst_n = 1'b0;
        push  = 1'b0;
        item  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // escape ending the string, mixed-case hex
        send_text(str2q("%fF"));
        // failed '&' restarts, string ends mid-entity
        send_text(str2q("&&gt"));
        // non-hex after a held digit
        send_text(str2q("%0g"));
        q = str2q("&#39;");
        q = {q, 8'h00};
        send_text(q);
        q = str2q("&quot;");
        q = {q, 8'hFF};
        send_text(q);
        send_text(str2q("&amp;&lt;"));
        send_text(str2q("%"));

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle = 16;
                    recv_idle = 54;
                end
                1:
                begin
                    send_idle = 54;
                    recv_idle = 16;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            target = (ph + 1) * TOTAL_ITEMS / 3;
            while (n_sent < target)
                send_text(make_text());
        end
        push <= 1'b0;

        while (sb.pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ percent_and_entity_decoder.f @@
hw/rtl/ped_pkg.sv
hw/rtl/ped_front.sv
hw/rtl/ped_job_fifo.sv
hw/rtl/ped_back.sv
hw/rtl/percent_and_entity_decoder.sv
tb/sv/tb_percent_and_entity_decoder.sv
